[rtl/core/waving_topk_flow_sketch_defines.svh]
// ----------------------------------------------------------------------------
// waving_topk_flow_sketch_defines.svh
// Assertion macros used by the waving sketch controller.
// ----------------------------------------------------------------------------
`ifndef WAVING_TOPK_FLOW_SKETCH_DEFINES_SVH
`define WAVING_TOPK_FLOW_SKETCH_DEFINES_SVH

// same-cycle implication, disabled in reset
`define WVTK_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled in reset
`define WVTK_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/core/wvtk_pkg.sv]
// ----------------------------------------------------------------------------
// wvtk_pkg
// Types, constants and helpers of the waving sketch top-k block.
// ----------------------------------------------------------------------------
`default_nettype none

package wvtk_pkg;

  localparam int BUCKETS_DEF          = 1024;
  localparam int CELLS_PER_BUCKET_DEF = 16;
  localparam int COUNT_BITS_DEF       = 32;

  localparam int KEY_W       = 104;
  localparam int KEY_HIGH_W  = 40;
  localparam int KEY_LOW_W   = 64;
  localparam int BKT_IN_W    = 10;
  localparam int CELL_IN_W   = 4;
  localparam int OUT_CNT_W   = 31;
  localparam int IN_TDATA_W  = 120;
  localparam int OUT_TDATA_W = 136;
  localparam int SEED_W      = 32;

  localparam logic [31:0] SEED_RESET = 32'd1324534127;
  localparam logic [31:0] KEY_BYTES  = 32'd13;

  // murmur3 x86_32 constants
  localparam logic [31:0] MUR_C1  = 32'hcc9e2d51;
  localparam logic [31:0] MUR_C2  = 32'h1b873593;
  localparam logic [31:0] MUR_ADD = 32'he6546b64;
  localparam logic [31:0] MUR_F1  = 32'h85ebca6b;
  localparam logic [31:0] MUR_F2  = 32'hc2b2ae35;

  typedef enum logic [1:0] {
    HP_IDLE,
    HP_MIX,
    HP_MOD
  } hsh_phase_e;

  typedef enum logic [3:0] {
    CS_CLEAR,
    CS_IDLE,
    CS_HSTART,
    CS_HASH,
    CS_BASE,
    CS_WCAP,
    CS_SCAN_RD,
    CS_SCAN_EV,
    CS_DECIDE,
    CS_REHASH,
    CS_ADJ,
    CS_REPLACE,
    CS_WAVE,
    CS_RD_ADDR,
    CS_RD_OUT
  } ctl_state_e;

  typedef struct packed {
    logic clr_en;
    logic in_ready;
    logic in_take;
    logic hash_start;
    logic hash_rekey;
    logic base_ld;
    logic wave_cap;
    logic scan_rd;
    logic scan_ev;
    logic rehash_adj;
    logic replace_wr;
    logic wave_wr;
    logic out_load;
  } ctrl_cmd_t;

  typedef struct packed {
    logic clr_last;
    logic hash_busy;
    logic ev_done;
    logic ev_last;
    logic do_replace;
    logic need_rehash;
    logic out_free;
  } dp_status_t;

  function automatic logic [31:0] rotl32(input logic [31:0] x, input int unsigned r);
    return (x << r) | (x >> (32 - r));
  endfunction

endpackage

`default_nettype wire

[rtl/core/waving_topk_flow_sketch.sv]
// ----------------------------------------------------------------------------
// waving_topk_flow_sketch
// Waving sketch top-k flow counter. After reset the block runs a clearing
// pass over all BUCKETS*CELLS_PER_BUCKET cells (16384 by default) with
// tready low. One item at a time is processed: a read may wait for the
// output register; an insert also hashes the old key again when an
// error-free cell is replaced. Insert time is set by the murmur3 unit
// (14 steps on one 32x32 multiplier), the bucket reduction by reciprocal
// multiplication (3 steps) and the bucket scan, a read and an evaluate state
// per cell through the registered read port of the cell memory. The seed may be
// written any time the block is idle.
// ----------------------------------------------------------------------------
`default_nettype none

module waving_topk_flow_sketch #(
  parameter int BUCKETS          = wvtk_pkg::BUCKETS_DEF,
  parameter int CELLS_PER_BUCKET = wvtk_pkg::CELLS_PER_BUCKET_DEF,
  parameter int COUNT_BITS       = wvtk_pkg::COUNT_BITS_DEF
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              s_axis_tvalid,
  output logic                                   s_axis_tready,
  // key_high[39:0], key_low[103:40], bucket_index[113:104], cell_index[117:114]
  input  wire logic [wvtk_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
  // kind[0]
  input  wire logic [0:0]                        s_axis_tuser,
  output logic                                   m_axis_tvalid,
  input  wire logic                              m_axis_tready,
  // out_key_high[39:0], out_key_low[103:40], out_count[134:104], error_free[135]
  output logic      [wvtk_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,
  input  wire logic                              cfg_valid_i,
  output logic                                   cfg_ready_o,
  input  wire logic [wvtk_pkg::SEED_W-1:0]       cfg_data_i
);

  import wvtk_pkg::*;

  ctrl_cmd_t  cmd;
  dp_status_t sts;

  wvtk_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_kind_i  (s_axis_tuser[0]),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  wvtk_dp #(
    .BUCKETS          (BUCKETS),
    .CELLS_PER_BUCKET (CELLS_PER_BUCKET),
    .COUNT_BITS       (COUNT_BITS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .s_tdata_i   (s_axis_tdata),
    .cfg_valid_i (cfg_valid_i),
    .cfg_data_i  (cfg_data_i),
    .m_tvalid_o  (m_axis_tvalid),
    .m_tready_i  (m_axis_tready),
    .m_tdata_o   (m_axis_tdata)
  );

  assign s_axis_tready = cmd.in_ready;
  assign cfg_ready_o   = 1'b1;

endmodule

`default_nettype wire

[rtl/core/wvtk_ram.sv]
// ----------------------------------------------------------------------------
// wvtk_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module wvtk_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  wire logic                                     clk_i,
  input  wire logic                                     we_i,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]                         wdata_i,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic      [WIDTH-1:0]                         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

[rtl/core/wvtk_hash.sv]
// ----------------------------------------------------------------------------
// wvtk_hash
// Multi-cycle murmur3 x86_32 of a 13-byte key with one shared multiplier,
// followed by a three-step reduction of hash[31:1] modulo the bucket count
// (reciprocal-multiply quotient estimate, remainder, one fold).
// ----------------------------------------------------------------------------
`default_nettype none

module wvtk_hash #(
  parameter int BUCKETS = wvtk_pkg::BUCKETS_DEF
) (
  input  wire logic                                         clk_i,
  input  wire logic                                         rst_ni,
  input  wire logic                                         start_i,
  input  wire logic [wvtk_pkg::KEY_W-1:0]                   key_i,
  input  wire logic [wvtk_pkg::SEED_W-1:0]                  seed_i,
  output logic                                              busy_o,
  output logic      [31:0]                                  hash_o,
  output logic      [((BUCKETS > 1) ? $clog2(BUCKETS) : 1)-1:0] bucket_o
);

  import wvtk_pkg::*;

  localparam int BAW = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
  localparam int RW  = $clog2(BUCKETS) + 2;
  localparam logic [3:0] LAST_STEP = 4'd13;
  localparam logic [4:0] LAST_MOD  = 5'd2;
  // floor(2^31 / BUCKETS)
  localparam logic [31:0] RECIP = 32'((64'd1 << 31) / 64'(BUCKETS));

  hsh_phase_e    phase_q, phase_d;
  logic [3:0]    step_q, step_d;
  logic [4:0]    mcnt_q, mcnt_d;
  logic [KEY_W-1:0] key_q;
  logic [31:0]   h_q, k_q, h_d, k_d;
  logic [30:0]   msh_q;
  logic [30:0]   quo_q;
  logic [61:0]   prod;
  logic [30:0]   rem_full;
  logic [RW-1:0] rem_q;
  logic [7:0]    kb [13];
  logic [31:0]   word [3];

  // key byte 0 sits in the top bits
  always_comb begin
    for (int j = 0; j < 13; j++) begin
      kb[j] = key_q[KEY_W-1-8*j -: 8];
    end
    for (int i = 0; i < 3; i++) begin
      word[i] = {kb[4*i+3], kb[4*i+2], kb[4*i+1], kb[4*i]};
    end
  end

  // at most one multiply per step, result registered
  always_comb begin
    logic [31:0] mix;
    logic [31:0] t;
    mix = rotl32(h_q ^ k_q, 13);
    t   = h_q ^ k_q ^ KEY_BYTES;
    t   = t ^ (t >> 16);
    h_d = h_q;
    k_d = k_q;
    case (step_q) inside
      4'd0:                     k_d = word[0] * MUR_C1;
      4'd3:                     k_d = word[1] * MUR_C1;
      4'd6:                     k_d = word[2] * MUR_C1;
      4'd9:                     k_d = {24'd0, kb[12]} * MUR_C1;
      4'd1, 4'd4, 4'd7, 4'd10:  k_d = rotl32(k_q, 15) * MUR_C2;
      4'd2, 4'd5, 4'd8:         h_d = (mix << 2) + mix + MUR_ADD;
      4'd11:                    h_d = t * MUR_F1;
      4'd12:                    h_d = (h_q ^ (h_q >> 13)) * MUR_F2;
      4'd13:                    h_d = h_q ^ (h_q >> 16);
      default: ;
    endcase
  end

  // quotient estimate is exact or one low, so the remainder is below 2*BUCKETS
  assign prod     = 62'(msh_q) * 62'(RECIP);
  assign rem_full = msh_q - quo_q * 31'(BUCKETS);

  always_comb begin
    phase_d = phase_q;
    step_d  = step_q;
    mcnt_d  = mcnt_q;
    unique case (phase_q)
      HP_IDLE: begin
        if (start_i) begin
          phase_d = HP_MIX;
          step_d  = '0;
        end
      end
      HP_MIX: begin
        step_d = step_q + 4'd1;
        if (step_q == LAST_STEP) begin
          phase_d = HP_MOD;
          mcnt_d  = '0;
        end
      end
      HP_MOD: begin
        mcnt_d = mcnt_q + 5'd1;
        if (mcnt_q == LAST_MOD) begin
          phase_d = HP_IDLE;
        end
      end
      default: phase_d = HP_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= HP_IDLE;
      step_q  <= '0;
      mcnt_q  <= '0;
    end else begin
      phase_q <= phase_d;
      step_q  <= step_d;
      mcnt_q  <= mcnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (phase_q == HP_IDLE && start_i) begin
      key_q <= key_i;
      h_q   <= seed_i;
      k_q   <= '0;
    end else if (phase_q == HP_MIX) begin
      h_q <= h_d;
      k_q <= k_d;
      if (step_q == LAST_STEP) begin
        msh_q <= h_d[31:1];
        rem_q <= '0;
      end
    end else if (phase_q == HP_MOD) begin
      if (mcnt_q == 5'd0) begin
        quo_q <= prod[61:31];
      end else if (mcnt_q == 5'd1) begin
        rem_q <= rem_full[RW-1:0];
      end else if (rem_q >= RW'(BUCKETS)) begin
        rem_q <= rem_q - RW'(BUCKETS);
      end
    end
  end

  assign busy_o   = (phase_q != HP_IDLE);
  assign hash_o   = h_q;
  assign bucket_o = rem_q[BAW-1:0];

endmodule

`default_nettype wire

[rtl/core/wvtk_dp.sv]
// ----------------------------------------------------------------------------
// wvtk_dp
// Datapath: cell and waving counter memories, hash unit, bucket scan,
// replacement arithmetic, seed register and output register.
// ----------------------------------------------------------------------------
`default_nettype none

module wvtk_dp #(
  parameter int BUCKETS          = wvtk_pkg::BUCKETS_DEF,
  parameter int CELLS_PER_BUCKET = wvtk_pkg::CELLS_PER_BUCKET_DEF,
  parameter int COUNT_BITS       = wvtk_pkg::COUNT_BITS_DEF
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire wvtk_pkg::ctrl_cmd_t                cmd_i,
  output wvtk_pkg::dp_status_t                    sts_o,
  input  wire logic [wvtk_pkg::IN_TDATA_W-1:0]    s_tdata_i,
  input  wire logic                               cfg_valid_i,
  input  wire logic [wvtk_pkg::SEED_W-1:0]        cfg_data_i,
  output logic                                    m_tvalid_o,
  input  wire logic                               m_tready_i,
  output logic      [wvtk_pkg::OUT_TDATA_W-1:0]   m_tdata_o
);

  import wvtk_pkg::*;

  localparam int NCELLS = BUCKETS * CELLS_PER_BUCKET;
  localparam int CAW    = (NCELLS > 1) ? $clog2(NCELLS) : 1;
  localparam int BAW    = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
  localparam int CIW    = (CELLS_PER_BUCKET > 1) ? $clog2(CELLS_PER_BUCKET) : 1;
  localparam int CB     = COUNT_BITS;
  localparam int DW     = KEY_W + CB;
  localparam logic signed [CB+1:0] SAT_HI = {3'b000, {(CB-1){1'b1}}};
  localparam logic signed [CB+1:0] SAT_LO = -SAT_HI;
  localparam logic signed [CB+1:0] ONE_X  = (CB+2)'(1);
  localparam logic signed [CB-1:0] NEG_ONE = {CB{1'b1}};

  function automatic logic signed [CB-1:0] sat_f(input logic signed [CB+1:0] v);
    logic signed [CB-1:0] r;
    if (v > SAT_HI) begin
      r = SAT_HI[CB-1:0];
    end else if (v < SAT_LO) begin
      r = SAT_LO[CB-1:0];
    end else begin
      r = v[CB-1:0];
    end
    return r;
  endfunction

  // control state
  logic [SEED_W-1:0] seed_q;
  logic [CAW-1:0]    clr_q;
  logic              out_valid_q;

  // payload state
  logic [KEY_W-1:0]     key_q;
  logic [CAW-1:0]       rd_addr_q;
  logic                 rd_ok_q;
  logic [CAW-1:0]       base_q;
  logic [BAW-1:0]       bkt_q;
  logic                 sign_q;
  logic signed [CB-1:0] w_q;
  logic [CIW-1:0]       idx_q;
  logic [CIW-1:0]       min_pos_q;
  logic [CB-2:0]        min_num_q;
  logic signed [CB-1:0] min_cnt_q;
  logic [KEY_W-1:0]     min_key_q;
  logic [KEY_W-1:0]     out_key_q;
  logic [OUT_CNT_W-1:0] out_cnt_q;
  logic                 out_ef_q;

  // memories
  logic           cell_we;
  logic [CAW-1:0] cell_waddr, cell_raddr;
  logic [DW-1:0]  cell_wdata, cell_rdata;
  logic           wave_we;
  logic [BAW-1:0] wave_waddr;
  logic [CB-1:0]  wave_wdata, wave_rdata;

  // hash unit
  logic             hsh_busy;
  logic [31:0]      hsh_hash;
  logic [BAW-1:0]   hsh_bkt;
  logic [KEY_W-1:0] hsh_key;

  // scan and arithmetic
  logic [KEY_W-1:0]     cell_key;
  logic signed [CB-1:0] cell_cnt;
  logic signed [CB-1:0] cell_abs_full;
  logic [CB-2:0]        cell_abs;
  logic                 cell_empty, cell_match;
  logic [CAW-1:0]       scan_addr;
  logic signed [CB+1:0] w_ext, sw_ext, min_ext;
  logic signed [CB-1:0] wave_plus, match_cnt, rep_cnt, adj_w;
  logic [31:0]          rd_lin;
  logic                 rd_in_range;

  assign hsh_key = cmd_i.hash_rekey ? min_key_q : key_q;

  wvtk_hash #(
    .BUCKETS (BUCKETS)
  ) u_hash (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (cmd_i.hash_start),
    .key_i    (hsh_key),
    .seed_i   (seed_q),
    .busy_o   (hsh_busy),
    .hash_o   (hsh_hash),
    .bucket_o (hsh_bkt)
  );

  wvtk_ram #(
    .WIDTH (DW),
    .DEPTH (NCELLS)
  ) u_cell_ram (
    .clk_i   (clk_i),
    .we_i    (cell_we),
    .waddr_i (cell_waddr),
    .wdata_i (cell_wdata),
    .raddr_i (cell_raddr),
    .rdata_o (cell_rdata)
  );

  wvtk_ram #(
    .WIDTH (CB),
    .DEPTH (BUCKETS)
  ) u_wave_ram (
    .clk_i   (clk_i),
    .we_i    (wave_we),
    .waddr_i (wave_waddr),
    .wdata_i (wave_wdata),
    .raddr_i (hsh_bkt),
    .rdata_o (wave_rdata)
  );

  assign cell_key      = cell_rdata[KEY_W-1:0];
  assign cell_cnt      = signed'(cell_rdata[DW-1:KEY_W]);
  assign cell_empty    = (cell_cnt == '0);
  assign cell_match    = (cell_key == key_q);
  assign cell_abs_full = cell_cnt[CB-1] ? -cell_cnt : cell_cnt;
  assign cell_abs      = cell_abs_full[CB-2:0];
  assign scan_addr     = base_q + CAW'(idx_q);
  assign cell_raddr    = cmd_i.scan_rd ? scan_addr : rd_addr_q;

  assign w_ext     = (CB+2)'(w_q);
  assign sw_ext    = sign_q ? -w_ext : w_ext;
  assign min_ext   = signed'((CB+2)'(min_num_q));
  assign wave_plus = sat_f(sign_q ? (w_ext - ONE_X) : (w_ext + ONE_X));
  assign match_cnt = cell_cnt[CB-1] ? sat_f((CB+2)'(cell_cnt) - ONE_X)
                                    : sat_f((CB+2)'(cell_cnt) + ONE_X);
  assign rep_cnt   = sat_f(min_ext + ONE_X);
  // rehash bit 0 set means the old key carried sign -1
  assign adj_w     = hsh_hash[0] ? sat_f(w_ext + (CB+2)'(min_cnt_q))
                                 : sat_f(w_ext - (CB+2)'(min_cnt_q));

  assign rd_lin = 32'(s_tdata_i[113:104]) * 32'(CELLS_PER_BUCKET)
                + 32'(s_tdata_i[117:114]);
  assign rd_in_range = (32'(s_tdata_i[113:104]) < 32'(BUCKETS)) &&
                       (32'(s_tdata_i[117:114]) < 32'(CELLS_PER_BUCKET));

  always_comb begin
    cell_we    = 1'b0;
    cell_waddr = scan_addr;
    cell_wdata = {NEG_ONE, key_q};
    if (cmd_i.clr_en) begin
      cell_we    = 1'b1;
      cell_waddr = clr_q;
      cell_wdata = '0;
    end else if (cmd_i.scan_ev && cell_empty) begin
      cell_we = 1'b1;
    end else if (cmd_i.scan_ev && cell_match) begin
      cell_we    = 1'b1;
      cell_wdata = {match_cnt, cell_key};
    end else if (cmd_i.replace_wr) begin
      cell_we    = 1'b1;
      cell_waddr = base_q + CAW'(min_pos_q);
      cell_wdata = {rep_cnt, key_q};
    end
  end

  always_comb begin
    wave_we    = 1'b0;
    wave_waddr = bkt_q;
    wave_wdata = wave_plus;
    if (cmd_i.clr_en) begin
      wave_we    = (32'(clr_q) < 32'(BUCKETS));
      wave_waddr = clr_q[BAW-1:0];
      wave_wdata = '0;
    end else if (cmd_i.scan_ev && !cell_empty && cell_match && !cell_cnt[CB-1]) begin
      wave_we = 1'b1;
    end else if (cmd_i.wave_wr) begin
      wave_we = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seed_q      <= SEED_RESET;
      clr_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        seed_q <= cfg_data_i;
      end
      if (cmd_i.clr_en) begin
        clr_q <= clr_q + CAW'(1);
      end
      if (cmd_i.out_load) begin
        out_valid_q <= 1'b1;
      end else if (m_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.in_take) begin
      key_q     <= {s_tdata_i[KEY_HIGH_W-1:0], s_tdata_i[KEY_HIGH_W+KEY_LOW_W-1:KEY_HIGH_W]};
      rd_addr_q <= rd_lin[CAW-1:0];
      rd_ok_q   <= rd_in_range;
    end
    if (cmd_i.base_ld) begin
      bkt_q  <= hsh_bkt;
      sign_q <= hsh_hash[0];
      base_q <= CAW'(hsh_bkt) * CAW'(CELLS_PER_BUCKET);
    end
    if (cmd_i.wave_cap) begin
      w_q   <= signed'(wave_rdata);
      idx_q <= '0;
    end else if (cmd_i.rehash_adj) begin
      w_q <= adj_w;
    end
    if (cmd_i.scan_ev) begin
      idx_q <= idx_q + CIW'(1);
      // strict compare keeps the lowest index among equal counts
      if (idx_q == '0 || cell_abs < min_num_q) begin
        min_num_q <= cell_abs;
        min_pos_q <= idx_q;
        min_cnt_q <= cell_cnt;
        min_key_q <= cell_key;
      end
    end
    if (cmd_i.out_load) begin
      if (rd_ok_q) begin
        out_key_q <= cell_key;
        out_cnt_q <= OUT_CNT_W'(cell_abs);
        out_ef_q  <= cell_cnt[CB-1];
      end else begin
        out_key_q <= '0;
        out_cnt_q <= '0;
        out_ef_q  <= 1'b0;
      end
    end
  end

  assign sts_o.clr_last    = (clr_q == CAW'(NCELLS - 1));
  assign sts_o.hash_busy   = hsh_busy;
  assign sts_o.ev_done     = cell_empty || cell_match;
  assign sts_o.ev_last     = (idx_q == CIW'(CELLS_PER_BUCKET - 1));
  assign sts_o.do_replace  = (sw_ext >= min_ext);
  assign sts_o.need_rehash = min_cnt_q[CB-1];
  assign sts_o.out_free    = !out_valid_q || m_tready_i;

  assign m_tvalid_o = out_valid_q;
  assign m_tdata_o  = {out_ef_q, out_cnt_q, out_key_q[KEY_LOW_W-1:0],
                       out_key_q[KEY_W-1:KEY_LOW_W]};

endmodule

`default_nettype wire

[rtl/core/wvtk_ctrl.sv]
// ----------------------------------------------------------------------------
// wvtk_ctrl
// Controller: clearing pass, insert sequence (hash, scan, replace, waving
// update) and read sequence.
// ----------------------------------------------------------------------------
`default_nettype none
`include "waving_topk_flow_sketch_defines.svh"

module wvtk_ctrl (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  in_valid_i,
  input  wire logic                  in_kind_i,
  input  wire wvtk_pkg::dp_status_t  sts_i,
  output wvtk_pkg::ctrl_cmd_t        cmd_o
);

  import wvtk_pkg::*;

  ctl_state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      CS_CLEAR:   if (sts_i.clr_last) state_d = CS_IDLE;
      CS_IDLE: begin
        if (in_valid_i) begin
          state_d = in_kind_i ? CS_RD_ADDR : CS_HSTART;
        end
      end
      CS_HSTART:  state_d = CS_HASH;
      CS_HASH:    if (!sts_i.hash_busy) state_d = CS_BASE;
      CS_BASE:    state_d = CS_WCAP;
      CS_WCAP:    state_d = CS_SCAN_RD;
      CS_SCAN_RD: state_d = CS_SCAN_EV;
      CS_SCAN_EV: begin
        if (sts_i.ev_done) begin
          state_d = CS_IDLE;
        end else if (sts_i.ev_last) begin
          state_d = CS_DECIDE;
        end else begin
          state_d = CS_SCAN_RD;
        end
      end
      CS_DECIDE: begin
        if (!sts_i.do_replace) begin
          state_d = CS_WAVE;
        end else if (sts_i.need_rehash) begin
          state_d = CS_REHASH;
        end else begin
          state_d = CS_REPLACE;
        end
      end
      CS_REHASH:  if (!sts_i.hash_busy) state_d = CS_ADJ;
      CS_ADJ:     state_d = CS_REPLACE;
      CS_REPLACE: state_d = CS_WAVE;
      CS_WAVE:    state_d = CS_IDLE;
      CS_RD_ADDR: state_d = CS_RD_OUT;
      CS_RD_OUT:  if (sts_i.out_free) state_d = CS_IDLE;
      default:    state_d = CS_IDLE;
    endcase
  end

  always_comb begin
    cmd_o = '0;
    unique case (state_q)
      CS_CLEAR:   cmd_o.clr_en = 1'b1;
      CS_IDLE: begin
        cmd_o.in_ready = 1'b1;
        cmd_o.in_take  = in_valid_i;
      end
      CS_HSTART:  cmd_o.hash_start = 1'b1;
      CS_HASH:    ;
      CS_BASE:    cmd_o.base_ld = 1'b1;
      CS_WCAP:    cmd_o.wave_cap = 1'b1;
      CS_SCAN_RD: cmd_o.scan_rd = 1'b1;
      CS_SCAN_EV: cmd_o.scan_ev = 1'b1;
      CS_DECIDE: begin
        if (sts_i.do_replace && sts_i.need_rehash) begin
          cmd_o.hash_start = 1'b1;
          cmd_o.hash_rekey = 1'b1;
        end
      end
      CS_REHASH:  ;
      CS_ADJ:     cmd_o.rehash_adj = 1'b1;
      CS_REPLACE: cmd_o.replace_wr = 1'b1;
      CS_WAVE:    cmd_o.wave_wr = 1'b1;
      CS_RD_ADDR: ;
      CS_RD_OUT:  cmd_o.out_load = sts_i.out_free;
      default:    ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= CS_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  `WVTK_ASSERT_IMPL(a_start_idle, clk_i, rst_ni, cmd_o.hash_start, !sts_i.hash_busy, "hash start while busy")
  `WVTK_ASSERT_NEXT(a_start_busy, clk_i, rst_ni, cmd_o.hash_start, sts_i.hash_busy, "hash unit did not start")
  `WVTK_ASSERT_NEXT(a_clear_once, clk_i, rst_ni, state_q != CS_CLEAR, state_q != CS_CLEAR, "clearing pass re-entered")
  `WVTK_ASSERT_NEXT(a_take_leave, clk_i, rst_ni, cmd_o.in_take, state_q != CS_IDLE, "transfer taken but controller stayed idle")

endmodule

`default_nettype wire
